FILE: sv/sorted_key_table_macros.svh
// Assertion macros for the sorted key table RTL.
// Included by the modules that carry concurrent assertions.
`ifndef SORTED_KEY_TABLE_MACROS_SVH
`define SORTED_KEY_TABLE_MACROS_SVH
`ifndef SYNTHESIS
// check outside reset
`define SKT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check the cycle after reset is applied
`define SKT_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) (!rst_n) |=> (prop)) else $error(msg);
`else
`define SKT_ASSERT(lbl, clk, rst_n, prop, msg)
`define SKT_ASSERT_RST(lbl, clk, rst_n, prop, msg)
`endif
`endif

FILE: sv/skt_pkg.sv
// Package for the sorted key table: request, response, entry and cell control types.
// No dependencies.
`default_nettype none
package skt_pkg;

  localparam int KEY_W      = 32;
  localparam int PAY_W      = 32;
  localparam int RANK_W     = 5;
  localparam int OCNT_W     = 6;
  localparam int CAPACITY_D = 32;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_FIND   = 2'd2,
    OP_RANK   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_DONE      = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_FULL      = 3'd3,
    ST_LAST_GONE = 3'd4
  } status_t;

  typedef struct packed {
    op_t                     opcode;
    logic signed [KEY_W-1:0] key;
    logic [PAY_W-1:0]        payload_bits;
    logic                    entry_kind;
    logic [RANK_W-1:0]       rank;
  } in_req_t;

  typedef struct packed {
    status_t                 status;
    logic signed [KEY_W-1:0] hit_key;
    logic [PAY_W-1:0]        hit_payload;
    logic                    hit_kind;
    logic [OCNT_W-1:0]       entry_count;
  } out_rsp_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [PAY_W-1:0]        payload;
    logic                    kind;
  } entry_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    op_t                     op;
    logic signed [KEY_W-1:0] key;
    logic [RANK_W-1:0]       rank;
    logic                    cmp;
    logic                    ins_en;
    logic                    del_en;
  } cell_ctl_t;

  // handed from a cell to its right neighbor
  typedef struct packed {
    logic eq;
    logic at;
  } cell_link_t;

endpackage
`default_nettype wire

FILE: sv/sorted_key_table.sv
// Sorted key table: a chain of CAPACITY cells kept in ascending signed key order.
// Flow: an accepted request passes a compare state, then an apply state that registers the result.
// A new request is taken only once the previous one has left apply (compare then select-and-shift
// pass over the cell row); apply waits while a previous result is still stalled.
// Reset: entry count cleared and no result pending; cell contents are not cleared.
// Depends on skt_pkg, skt_cell and sorted_key_table_macros.svh.
`default_nettype none
`include "sorted_key_table_macros.svh"
module sorted_key_table #(
  parameter int CAPACITY = skt_pkg::CAPACITY_D
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  skt_pkg::in_req_t  in_req,
  output logic              out_valid,
  input  logic              out_stall,
  output skt_pkg::out_rsp_t out_rsp
);
  import skt_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {S_IDLE, S_CMP, S_APPLY} state_t;

  state_t           state_r;
  in_req_t          req_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r;
  out_rsp_t         out_rsp_r, rsp_nxt;

  cell_ctl_t        ctl;
  entry_t           ent_new;
  entry_t           ent    [CAPACITY];
  cell_link_t       lnk    [CAPACITY];
  logic [CAPACITY-1:0] hit_vec;

  logic   go, found, full, empty, in_acc;
  entry_t hit_ent;

  assign in_acc = in_valid && !in_stall;
  assign go     = (state_r == S_APPLY) && (!out_valid_r || !out_stall);
  assign full   = count_r >= CNT_W'(CAPACITY);
  assign empty  = count_r == '0;
  assign found  = |hit_vec;

  always_comb begin
    hit_ent = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (hit_vec[i]) hit_ent = hit_ent | ent[i];
    end
  end

  assign ent_new.key     = req_r.key;
  assign ent_new.payload = req_r.payload_bits;
  assign ent_new.kind    = req_r.entry_kind;

  always_comb begin
    ctl.op     = req_r.opcode;
    ctl.key    = req_r.key;
    ctl.rank   = req_r.rank;
    ctl.cmp    = state_r == S_CMP;
    ctl.ins_en = go && (req_r.opcode == OP_INSERT) && !full;
    ctl.del_en = go && (req_r.opcode == OP_DELETE) && found;
  end

  always_comb begin
    count_nxt = count_r;
    rsp_nxt   = '0;
    rsp_nxt.status = ST_DONE;
    if (req_r.opcode == OP_INSERT) begin
      if (full) rsp_nxt.status = ST_FULL;
      else      count_nxt = count_r + 1'b1;
    end else if (empty) begin
      rsp_nxt.status = ST_EMPTY;
    end else if (!found) begin
      rsp_nxt.status = ST_NOT_FOUND;
    end else if (req_r.opcode == OP_DELETE) begin
      count_nxt      = count_r - 1'b1;
      rsp_nxt.status = (count_r == CNT_W'(1)) ? ST_LAST_GONE : ST_DONE;
    end else begin
      rsp_nxt.hit_key     = hit_ent.key;
      rsp_nxt.hit_payload = hit_ent.payload;
      rsp_nxt.hit_kind    = hit_ent.kind;
    end
    rsp_nxt.entry_count = OCNT_W'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (go)              out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE:  if (in_acc) state_r <= S_CMP;
        S_CMP:   state_r <= S_APPLY;
        S_APPLY: begin
          if (go) begin
            state_r <= S_IDLE;
            count_r <= count_nxt;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
    if (in_acc) req_r <= in_req;
    if (go) out_rsp_r <= rsp_nxt;
  end

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t     left_ent, right_ent;
    cell_link_t left_lnk;
    if (i == 0) begin : g_head
      assign left_ent = '0;
      assign left_lnk = '0;
    end else begin : g_mid
      assign left_ent = ent[i-1];
      assign left_lnk = lnk[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_ent = ent[i];
    end else begin : g_body
      assign right_ent = ent[i+1];
    end
    skt_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .count     (count_r),
      .ent_new   (ent_new),
      .ent_left  (left_ent),
      .ent_right (right_ent),
      .link_left (left_lnk),
      .ent       (ent[i]),
      .link      (lnk[i]),
      .hit       (hit_vec[i])
    );
  end

  `SKT_ASSERT(a_count_max, clk, rst_n, count_r <= CNT_W'(CAPACITY), "entry count above capacity")
  `SKT_ASSERT(a_hit_onehot, clk, rst_n, (state_r == S_APPLY) |-> $onehot0(hit_vec), "multiple cells hit")
  `SKT_ASSERT(a_acc_cmp, clk, rst_n, in_acc |=> (state_r == S_CMP), "accepted request not compared")
  `SKT_ASSERT(a_full_hold, clk, rst_n, (go && req_r.opcode == OP_INSERT && full) |=> $stable(count_r), "insert into full table changed count")
  `SKT_ASSERT_RST(a_reset, clk, rst_n, count_r == '0 && !out_valid_r, "reset did not clear control state")

endmodule
`default_nettype wire

FILE: sv/skt_cell.sv
// One table cell: holds an entry, compares it with the request key and
// shifts toward its neighbors. Depends on skt_pkg.
`default_nettype none
module skt_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 6
) (
  input  logic                clk,
  input  logic                rst_n,
  input  skt_pkg::cell_ctl_t  ctl,
  input  logic [CNT_W-1:0]    count,
  input  skt_pkg::entry_t     ent_new,
  input  skt_pkg::entry_t     ent_left,
  input  skt_pkg::entry_t     ent_right,
  input  skt_pkg::cell_link_t link_left,
  output skt_pkg::entry_t     ent,
  output skt_pkg::cell_link_t link,
  output logic                hit
);
  import skt_pkg::*;

  entry_t ent_r, ent_nxt;
  logic   at_r, at_nxt;
  logic   hit_r, hit_nxt;
  logic   valid, eq, gt, ge, rank_eq;

  always_comb begin
    valid   = 32'(count) > 32'(IDX);
    eq      = valid && (ent_r.key == ctl.key);
    gt      = valid && ($signed(ent_r.key) > $signed(ctl.key));
    ge      = valid && ($signed(ent_r.key) >= $signed(ctl.key));
    rank_eq = 32'(ctl.rank) == 32'(IDX);

    at_nxt  = at_r;
    hit_nxt = hit_r;
    if (ctl.cmp) begin
      // insert: at or past the slot; delete: at or past the first match
      at_nxt = (ctl.op == OP_INSERT) ? (gt || !valid) : (ge || !valid);
      case (ctl.op)
        OP_RANK:           hit_nxt = valid && rank_eq;
        OP_DELETE, OP_FIND: hit_nxt = eq && !link_left.eq;
        default:           hit_nxt = 1'b0;
      endcase
    end

    ent_nxt = ent_r;
    if (ctl.ins_en && at_r) begin
      ent_nxt = link_left.at ? ent_left : ent_new;
    end else if (ctl.del_en && at_r) begin
      ent_nxt = ent_right;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      at_r  <= 1'b0;
      hit_r <= 1'b0;
    end else begin
      at_r  <= at_nxt;
      hit_r <= hit_nxt;
    end
    ent_r <= ent_nxt;
  end

  assign ent     = ent_r;
  assign link.eq = eq;
  assign link.at = at_r;
  assign hit     = hit_r;

endmodule
`default_nettype wire
